FILE: rtl/assert_macros.svh
// assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is low
`define DMSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is low
`define DMSD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/dmsd_pkg.sv
package dmsd_pkg;

  localparam int unsigned IntervalW = 8;
  localparam int unsigned StepW     = 9;
  localparam int unsigned TimeoutW  = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned SpeedW    = 9;
  localparam int unsigned AgeW      = 17;

  localparam logic [IntervalW-1:0] IntervalRst = 8'd20;
  localparam logic [StepW-1:0]     StepRst     = 9'd10;
  localparam logic [TimeoutW-1:0]  TimeoutRst  = 16'd1000;
  localparam logic [AgeW-1:0]      AgeMax      = {AgeW{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RAMP_INTERVAL = 2'd0,
    CFG_STEP_LIMIT    = 2'd1,
    CFG_CMD_TIMEOUT   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_e;

  typedef struct packed {
    logic [IntervalW-1:0] ramp_interval;
    logic [StepW-1:0]     step_limit;
    logic [TimeoutW-1:0]  command_timeout;
  } cfg_t;

  typedef struct packed {
    logic [7:0] left_duty;
    dir_e       left_direction;
    logic [7:0] right_duty;
    dir_e       right_direction;
    logic [7:0] command_id;
    logic       frame_done;
  } result_t;

endpackage

FILE: rtl/dmsd_ifs.sv
interface dmsd_item_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, kind, data_byte, input ready);
  modport sink   (input valid, kind, data_byte, output ready);
endinterface

interface dmsd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] left_duty;
  logic [1:0] left_direction;
  logic [7:0] right_duty;
  logic [1:0] right_direction;
  logic [7:0] command_id;
  logic       frame_done;

  modport source (output valid, left_duty, left_direction, right_duty, right_direction,
                  command_id, frame_done, input ready);
  modport sink   (input valid, left_duty, left_direction, right_duty, right_direction,
                  command_id, frame_done, output ready);
endinterface

interface dmsd_cfg_if import dmsd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/dmsd_cfg_regs.sv
module dmsd_cfg_regs
  import dmsd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [CfgIdxW-1:0]  wr_index_i,
  input  logic [CfgDataW-1:0] wr_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (cfg_idx_e'(wr_index_i))
        CFG_RAMP_INTERVAL: cfg_d.ramp_interval   = wr_data_i[IntervalW-1:0];
        CFG_STEP_LIMIT:    cfg_d.step_limit      = wr_data_i[StepW-1:0];
        CFG_CMD_TIMEOUT:   cfg_d.command_timeout = wr_data_i[TimeoutW-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ramp_interval   <= IntervalRst;
      cfg_q.step_limit      <= StepRst;
      cfg_q.command_timeout <= TimeoutRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/dmsd_core.sv
module dmsd_core
  import dmsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       kind_i,
  input  logic [7:0] data_byte_i,
  input  cfg_t       cfg_i,
  output result_t    result_o
);

  // move cur toward tgt by at most step
  function automatic logic signed [SpeedW-1:0] slew(
    input logic signed [SpeedW-1:0] cur,
    input logic signed [SpeedW-1:0] tgt,
    input logic [StepW-1:0]         step
  );
    logic signed [SpeedW:0] diff;
    logic [SpeedW:0]        mag;
    logic signed [SpeedW:0] moved;
    diff  = SpeedW'(0) + ({tgt[SpeedW-1], tgt} - {cur[SpeedW-1], cur});
    mag   = diff[SpeedW] ? (~diff + 1'b1) : diff;
    moved = diff[SpeedW] ? ({cur[SpeedW-1], cur} - $signed({1'b0, step}))
                         : ({cur[SpeedW-1], cur} + $signed({1'b0, step}));
    if (diff == '0) begin
      slew = cur;
    end else if (mag <= {1'b0, step}) begin
      slew = tgt;
    end else begin
      slew = moved[SpeedW-1:0];
    end
  endfunction

  // byte b maps to 2*b - 255
  function automatic logic signed [SpeedW-1:0] speed_of(input logic [7:0] b);
    speed_of = {~b[7], b[6:0], 1'b1};
  endfunction

  function automatic logic [7:0] duty_of(input logic signed [SpeedW-1:0] v);
    logic [SpeedW-1:0] m;
    m = v[SpeedW-1] ? (~v + 1'b1) : v;
    duty_of = m[7:0];
  endfunction

  function automatic dir_e dir_of(input logic signed [SpeedW-1:0] v);
    if (v[SpeedW-1]) begin
      dir_of = DIR_REV;
    end else if (v != '0) begin
      dir_of = DIR_FWD;
    end else begin
      dir_of = DIR_STOP;
    end
  endfunction

  logic [1:0]               pos_q, pos_d;
  logic [7:0]               id_byte_q, left_byte_q;
  logic signed [SpeedW-1:0] left_cur_q, left_cur_d, right_cur_q, right_cur_d;
  logic signed [SpeedW-1:0] left_tgt_q, left_tgt_d, right_tgt_q, right_tgt_d;
  logic [IntervalW-1:0]     elapsed_q, elapsed_d;
  logic [AgeW-1:0]          age_q, age_d;
  logic [7:0]               last_id_q, last_id_d;
  logic                     done;
  logic [IntervalW:0]       elapsed_inc;
  logic [AgeW-1:0]          age_inc;
  logic                     ramp_now;

  assign elapsed_inc = {1'b0, elapsed_q} + 1'b1;
  assign ramp_now    = elapsed_inc >= {1'b0, cfg_i.ramp_interval};
  assign age_inc     = (age_q == AgeMax) ? age_q : age_q + 1'b1;

  always_comb begin
    pos_d       = pos_q;
    left_cur_d  = left_cur_q;
    right_cur_d = right_cur_q;
    left_tgt_d  = left_tgt_q;
    right_tgt_d = right_tgt_q;
    elapsed_d   = elapsed_q;
    age_d       = age_q;
    last_id_d   = last_id_q;
    done        = 1'b0;
    if (!kind_i) begin
      if (pos_q >= 2'd2) begin
        // third byte closes the frame
        last_id_d   = id_byte_q;
        left_tgt_d  = speed_of(left_byte_q);
        right_tgt_d = speed_of(data_byte_i);
        age_d       = '0;
        pos_d       = '0;
        done        = 1'b1;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end else begin
      age_d = age_inc;
      if (ramp_now) begin
        elapsed_d   = '0;
        left_cur_d  = slew(left_cur_q, left_tgt_q, cfg_i.step_limit);
        right_cur_d = slew(right_cur_q, right_tgt_q, cfg_i.step_limit);
      end else begin
        elapsed_d = elapsed_inc[IntervalW-1:0];
      end
      // stale command, set both speed targets to zero
      if (age_inc > {1'b0, cfg_i.command_timeout}) begin
        left_tgt_d  = '0;
        right_tgt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      left_cur_q  <= '0;
      right_cur_q <= '0;
      left_tgt_q  <= '0;
      right_tgt_q <= '0;
      elapsed_q   <= '0;
      age_q       <= '0;
      last_id_q   <= '0;
    end else if (step_i) begin
      pos_q       <= pos_d;
      left_cur_q  <= left_cur_d;
      right_cur_q <= right_cur_d;
      left_tgt_q  <= left_tgt_d;
      right_tgt_q <= right_tgt_d;
      elapsed_q   <= elapsed_d;
      age_q       <= age_d;
      last_id_q   <= last_id_d;
    end
  end

  // frame byte buffer, no reset
  always_ff @(posedge clk_i) begin
    if (step_i && !kind_i && pos_q == 2'd0) begin
      id_byte_q <= data_byte_i;
    end
    if (step_i && !kind_i && pos_q == 2'd1) begin
      left_byte_q <= data_byte_i;
    end
  end

  always_comb begin
    result_o.left_duty       = duty_of(left_cur_d);
    result_o.left_direction  = dir_of(left_cur_d);
    result_o.right_duty      = duty_of(right_cur_d);
    result_o.right_direction = dir_of(right_cur_d);
    result_o.command_id      = last_id_d;
    result_o.frame_done      = done;
  end

endmodule

FILE: rtl/dual_motor_slew_limited_drive.sv
// dual motor drive with slew-rate limited speed ramps
//
// item_i carries one item per handshake: kind 0 is a received command byte,
// kind 1 is a one millisecond tick. three bytes (identifier, left, right)
// form a command frame that sets both speed targets; ticks advance the ramp
// and the command-age timeout. every item gives exactly one result item on
// result_o with duty and direction for each motor, the last command id and
// a frame-done flag.
// cfg_i writes ramp_interval (0), step_limit (1) and command_timeout (2);
// it is always ready. the user must see that it is written only while the
// block is idle; the block itself does not enforce this. an item passes the
// input register, then the result register; one item per cycle sustained while
// result_o is ready, set by the single state update between the two registers.
// reset: speeds, targets, counters and the byte position clear, registers
// take their defaults, nothing is valid.
// a stalled receiver holds the result; one more item waits in the input
// register, and only then does item_i.ready drop.
module dual_motor_slew_limited_drive
  import dmsd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  dmsd_item_if.sink     item_i,
  dmsd_result_if.source result_o,
  dmsd_cfg_if.sink      cfg_i
);

  cfg_t    cfg;
  result_t result;

  // input register
  logic       in_v_q;
  logic       in_kind_q;
  logic [7:0] in_byte_q;

  // result register
  logic    out_v_q;
  result_t out_q;

  logic out_load;   // result register can take the held item
  logic in_take;

  assign out_load = !out_v_q || result_o.ready;
  assign in_take  = item_i.valid && item_i.ready;

  assign item_i.ready = !in_v_q || out_load;
  assign cfg_i.ready  = 1'b1;

  dmsd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  // state advances when the held item moves into the result register
  dmsd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_v_q && out_load),
    .kind_i      (in_kind_q),
    .data_byte_i (in_byte_q),
    .cfg_i       (cfg),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (item_i.ready) begin
        in_v_q <= item_i.valid;
      end
      if (out_load) begin
        out_v_q <= in_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_kind_q <= item_i.kind;
      in_byte_q <= item_i.data_byte;
    end
    if (out_load && in_v_q) begin
      out_q <= result;
    end
  end

  assign result_o.valid           = out_v_q;
  assign result_o.left_duty       = out_q.left_duty;
  assign result_o.left_direction  = out_q.left_direction;
  assign result_o.right_duty      = out_q.right_duty;
  assign result_o.right_direction = out_q.right_direction;
  assign result_o.command_id      = out_q.command_id;
  assign result_o.frame_done      = out_q.frame_done;

endmodule

FILE: rtl/dmsd_checker.sv
`include "assert_macros.svh"

module dmsd_checker
  import dmsd_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] left_duty_i,
  input logic [1:0] left_dir_i,
  input logic [7:0] right_duty_i,
  input logic [1:0] right_dir_i,
  input logic [7:0] command_id_i,
  input logic       frame_done_i
);

  // a held result keeps its duties, command id and frame-done flag
  `DMSD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(left_duty_i) && $stable(right_duty_i) && $stable(command_id_i) && $stable(frame_done_i), "result changed while stalled")

  // zero duty goes with stopped direction
  `DMSD_ASSERT_IMP(a_left_dir, clk_i, rst_ni, out_valid_i, (left_duty_i == 8'd0) == (left_dir_i == DIR_STOP), "left duty and direction disagree")
  `DMSD_ASSERT_IMP(a_right_dir, clk_i, rst_ni, out_valid_i, (right_duty_i == 8'd0) == (right_dir_i == DIR_STOP), "right duty and direction disagree")

  // input back-pressure only comes from a stalled result
  `DMSD_ASSERT_IMP(a_backpressure, clk_i, rst_ni, !in_ready_i, out_valid_i && !out_ready_i, "input stalled without output stall")

endmodule

bind dual_motor_slew_limited_drive dmsd_checker u_dmsd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (item_i.ready),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .left_duty_i  (result_o.left_duty),
  .left_dir_i   (result_o.left_direction),
  .right_duty_i (result_o.right_duty),
  .right_dir_i  (result_o.right_direction),
  .command_id_i (result_o.command_id),
  .frame_done_i (result_o.frame_done)
);
